>>> rtl/utf32_to_utf8_encoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 encoder assertion macros
// Shared property wrappers for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF32_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF32_TO_UTF8_ENCODER_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define UTF8E_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8e: same-cycle check failed");

// Next-cycle implication, quiet during reset
`define UTF8E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8e: next-cycle check failed");

`endif

>>> rtl/utf8e_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 encoder package
// Payload types, status codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package utf8e_pkg;

    localparam int unsigned JOB_DEPTH = 2;
    localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NUL     = 2'd1,
        ST_NOROOM  = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] code_point;
        logic        final_item;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_of_run;
        t_status     status;
        logic [15:0] bytes_total;
    } t_result;

    // One classified item: up to four bytes, first byte in seq[0]
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [1:0]      len_m1;
        logic            byte_valid;
        t_status         status;
        logic [15:0]     base;
    } t_job;

endpackage

>>> rtl/utf8e_front.sv
// ----------------------------------------------------------------------------
// UTF-8 encoder front end
// Accepts code points, encodes and checks them against the capacity, keeps
// the string byte count and halt flag, and issues one job per transaction.
// ----------------------------------------------------------------------------
module utf8e_front import utf8e_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    input  logic        i_q_full,
    output logic        o_full,
    output logic        o_job_push,
    output t_job        o_job,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_capacity;
    logic [15:0] r_bytes_used;
    logic        r_halted;
    logic [15:0] n_bytes_used;
    logic        n_halted;

    logic        accept;
    logic [31:0] cp;
    logic        is1, is2, is4, repl;
    logic [15:0] cp3;
    logic [1:0]  len_m1;
    logic [3:0][7:0] seq;
    logic [16:0] sum;
    logic        fits;

    assign accept      = i_push && !i_q_full;
    assign o_full      = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign o_job_push  = accept;
    assign cp          = i_item.code_point;

    always_comb begin
        is1  = cp < 32'h80;
        is2  = !is1 && (cp < 32'h800);
        is4  = (cp >= 32'h1_0000) && (cp < 32'h11_0000);
        repl = (cp >= 32'h11_0000) || ((cp >= 32'hD800) && (cp <= 32'hDFFF));
        cp3  = repl ? 16'hFFFD : cp[15:0];
        seq  = '0;
        priority if (is1) begin
            len_m1 = 2'd0;
            seq[0] = cp[7:0];
        end else if (is2) begin
            len_m1 = 2'd1;
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
        end else if (is4) begin
            len_m1 = 2'd3;
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
        end else begin
            len_m1 = 2'd2;
            seq[0] = {4'b1110, cp3[15:12]};
            seq[1] = {2'b10, cp3[11:6]};
            seq[2] = {2'b10, cp3[5:0]};
        end
        sum  = {1'b0, r_bytes_used} + {15'd0, len_m1} + 17'd1;
        fits = sum <= {1'b0, r_capacity};
    end

    always_comb begin
        o_job            = '0;
        o_job.base       = r_bytes_used;
        n_bytes_used     = r_bytes_used;
        n_halted         = r_halted;
        priority if (r_halted) begin
            o_job.status = ST_IGNORED;
        end else if (!fits) begin
            o_job.status = ST_NOROOM;
            n_halted     = 1'b1;
        end else if (cp == 32'd0) begin
            o_job.status     = ST_NUL;
            o_job.byte_valid = 1'b1;
            n_bytes_used     = sum[15:0];
            n_halted         = 1'b1;
        end else begin
            o_job.status     = ST_OK;
            o_job.byte_valid = 1'b1;
            o_job.seq        = seq;
            o_job.len_m1     = len_m1;
            n_bytes_used     = sum[15:0];
        end
        // final item rearms for the next string whatever happened
        if (i_item.final_item) begin
            n_bytes_used = '0;
            n_halted     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= 16'hFFFF;
            r_bytes_used <= '0;
            r_halted     <= 1'b0;
        end else if (i_cfg_valid) begin
            r_capacity   <= i_cfg_data;
            r_bytes_used <= '0;
            r_halted     <= 1'b0;
        end else if (accept) begin
            r_bytes_used <= n_bytes_used;
            r_halted     <= n_halted;
        end
    end

endmodule

>>> rtl/utf8e_fifo.sv
// ----------------------------------------------------------------------------
// UTF-8 encoder job queue
// Short FIFO of classified jobs between the front end and the serialiser.
// ----------------------------------------------------------------------------
module utf8e_fifo import utf8e_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = r_count == JOB_CNT_W'(JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/utf8e_back.sv
// ----------------------------------------------------------------------------
// UTF-8 encoder back end
// Walks each job one byte per cycle into a registered result stage, while that stage is free to load.
// ----------------------------------------------------------------------------
module utf8e_back import utf8e_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic    r_valid;
    logic [1:0] r_idx;
    t_result r_result;
    t_result n_result;
    logic    load;
    logic    take;
    logic    last;

    // result stage frees up when empty or being taken this cycle
    assign load      = !r_valid || i_pop;
    assign take      = load && i_job_valid;
    assign last      = r_idx == i_job.len_m1;
    assign o_job_pop = take && last;
    assign o_empty   = !r_valid;
    assign o_result  = r_result;

    always_comb begin
        n_result             = '0;
        n_result.out_byte    = i_job.seq[r_idx];
        n_result.byte_valid  = i_job.byte_valid;
        n_result.last_of_run = last;
        n_result.status      = i_job.status;
        n_result.bytes_total = i_job.base + {14'd0, r_idx} + {15'd0, i_job.byte_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= i_job_valid;
            end
            if (take) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

endmodule

>>> rtl/utf32_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// UTF-32 to UTF-8 encoder
// Each accepted code point yields its UTF-8 bytes, one result per byte, or a
// single result (NUL, no room, ignored while halted). The front end takes
// a code point every cycle while its two-entry job queue has room; the back
// end drives one result per cycle while the receiver pops. The result port
// is the limit on sustained rate. A result passes through the job queue and
// the registered result stage before it appears on the ports. The capacity
// write channel is always ready and needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module utf32_to_utf8_encoder import utf8e_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    `include "utf32_to_utf8_encoder_assert.svh"

    t_job q_in;
    t_job q_out;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    utf8e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_full      (o_full),
        .o_job_push  (q_push),
        .o_job       (q_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    utf8e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    utf8e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_out),
        .o_job_pop   (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

    // nothing can appear at the output without a queued job behind it
    `UTF8E_ASSERT_NEXT(a_no_invented_result, i_clk, i_rst_n, o_empty && q_empty, o_empty)
    // every accepted transaction lands in the job queue
    `UTF8E_ASSERT_NEXT(a_push_queued, i_clk, i_rst_n, i_push && !o_full, !q_empty)
    // the back end only retires a job that is present
    `UTF8E_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, q_pop, !q_empty)

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// UTF-32 to UTF-8 encoder testbench
// Sends code points through the input queue and encodes each one in the
// testbench. Every popped result is checked field by field against the
// oldest predicted result. The tests cover every encoding length, the
// substitution of invalid code points, the NUL and no-room halts, the
// final-item rearm and capacity writes. Both sides idle at random. The test
// also holds off the receiver long enough for the input to stall, and runs a
// burst with no idling at all.
// ----------------------------------------------------------------------------
module testbench;
    import utf8e_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_push      = 1'b0;
    t_item       i_item      = '0;
    logic        i_pop       = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_full;
    logic        o_empty;
    logic        o_cfg_ready;
    t_result     o_result;

    // Encoder state as predicted from the accepted transactions
    logic [15:0] pred_capacity = 16'hFFFF;
    logic [15:0] pred_used     = '0;
    logic        pred_halted   = 1'b0;
    t_result     utf8_expected[$];

    bit          idle_en   = 1'b1;
    bit          stall_req = 1'b0;
    int unsigned err_count      = 0;
    int unsigned items_sent     = 0;
    int unsigned results_popped = 0;
    int unsigned cfg_writes     = 0;

    localparam int unsigned STALL_CYCLES = 100;

    utf32_to_utf8_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin : watchdog
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // Works out the results of one accepted code point and updates the state
    task automatic encode_code_point(input t_item it);
        logic [7:0]  seq [0:3];
        logic [31:0] cp;
        logic [15:0] u;
        int unsigned n;
        t_result     r;
        cp = it.code_point;
        if (cp < 32'h80) begin
            n = 1;
            seq[0] = cp[7:0];
        end else if (cp < 32'h800) begin
            n = 2;
            seq[0] = 8'hC0 | {3'b000, cp[10:6]};
            seq[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp >= 32'h10000 && cp < 32'h110000) begin
            n = 4;
            seq[0] = 8'hF0 | {5'b00000, cp[20:18]};
            seq[1] = 8'h80 | {2'b00, cp[17:12]};
            seq[2] = 8'h80 | {2'b00, cp[11:6]};
            seq[3] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            // surrogates and out-of-range values become U+FFFD
            if (cp >= 32'h110000 || (cp >= 32'hD800 && cp <= 32'hDFFF))
                u = 16'hFFFD;
            else
                u = cp[15:0];
            n = 3;
            seq[0] = 8'hE0 | {4'b0000, u[15:12]};
            seq[1] = 8'h80 | {2'b00, u[11:6]};
            seq[2] = 8'h80 | {2'b00, u[5:0]};
        end

        r = '0;
        r.last_of_run = 1'b1;
        if (pred_halted) begin
            r.status      = ST_IGNORED;
            r.bytes_total = pred_used;
            utf8_expected.push_back(r);
        end else if ({16'd0, pred_used} + n > {16'd0, pred_capacity}) begin
            r.status      = ST_NOROOM;
            r.bytes_total = pred_used;
            pred_halted   = 1'b1;
            utf8_expected.push_back(r);
        end else if (cp == 32'd0) begin
            pred_used     = pred_used + 16'd1;
            r.byte_valid  = 1'b1;
            r.status      = ST_NUL;
            r.bytes_total = pred_used;
            pred_halted   = 1'b1;
            utf8_expected.push_back(r);
        end else begin
            for (int k = 0; k < n; k++) begin
                pred_used     = pred_used + 16'd1;
                r.out_byte    = seq[k];
                r.byte_valid  = 1'b1;
                r.last_of_run = (k == n - 1);
                r.status      = ST_OK;
                r.bytes_total = pred_used;
                utf8_expected.push_back(r);
            end
        end

        if (it.final_item) begin
            pred_used   = '0;
            pred_halted = 1'b0;
        end
    endtask

    // One input transaction; push is left high for a back-to-back follow-up
    task automatic send_item(input logic [31:0] cp, input logic fin);
        t_item       it;
        int unsigned gap;
        it.code_point = cp;
        it.final_item = fin;
        gap = 0;
        if (idle_en)
            while ($urandom_range(99) < 35) gap++;
        if (gap != 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        encode_code_point(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_push <= 1'b0;
        while (utf8_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        pred_capacity  = cap;
        pred_used      = '0;
        pred_halted    = 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [31:0] rand_code_point();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)      return $urandom_range(32'h7F, 32'h1);
        else if (pick < 45) return $urandom_range(32'h7FF, 32'h80);
        else if (pick < 65) return $urandom_range(32'hFFFF, 32'h800);
        else if (pick < 82) return $urandom_range(32'h10FFFF, 32'h10000);
        else if (pick < 89) return $urandom_range(32'hDFFF, 32'hD800);
        else if (pick < 97) return $urandom_range(32'hFFFFFFFF, 32'h110000);
        else                return 32'd0;
    endfunction

    task automatic test_directed_encodings();
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_007F, 1'b0);
        send_item(32'h0000_0080, 1'b0);
        send_item(32'h0000_07FF, 1'b0);
        send_item(32'h0000_0800, 1'b0);
        send_item(32'h0000_D7FF, 1'b0);
        send_item(32'h0000_D800, 1'b0);
        send_item(32'h0000_DFFF, 1'b0);
        send_item(32'h0000_E000, 1'b0);
        send_item(32'h0000_FFFF, 1'b0);
        send_item(32'h0001_0000, 1'b0);
        send_item(32'h0010_FFFF, 1'b0);
        send_item(32'h0011_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);   // NUL ends the string
        send_item(32'h0000_0041, 1'b0);   // ignored
        send_item(32'h0000_0042, 1'b1);   // ignored, then rearmed
        send_item(32'h0000_0043, 1'b1);
        send_item(32'h0000_0000, 1'b1);   // NUL and final together
        send_item(32'h0000_0044, 1'b0);
    endtask

    task automatic test_capacity_edges();
        write_capacity(16'd0);
        send_item(32'h41, 1'b0);          // no room at all
        send_item(32'h00, 1'b0);
        send_item(32'h42, 1'b1);
        send_item(32'h00, 1'b1);          // NUL also needs room
        write_capacity(16'd1);
        send_item(32'h00, 1'b0);          // NUL fits exactly
        send_item(32'h41, 1'b1);
        write_capacity(16'd5);
        send_item(32'h24, 1'b0);
        send_item(32'h1F600, 1'b0);       // fills to the brim
        send_item(32'h41, 1'b0);
        send_item(32'h41, 1'b1);
        send_item(32'h20AC, 1'b0);
        send_item(32'h3A9, 1'b0);
        send_item(32'h10348, 1'b1);       // four bytes over a full buffer
        write_capacity(16'd3);
        send_item(32'hDC00, 1'b0);        // replacement char just fits
        send_item(32'h41, 1'b1);
        write_capacity(16'hFFFF);
    endtask

    task automatic test_random_strings();
        int unsigned target, len, pick;
        logic        fin;
        target = items_sent + 360;
        while (items_sent < target) begin
            if ($urandom_range(1) == 0) begin
                pick = $urandom_range(99);
                if (pick < 70)      write_capacity(16'($urandom_range(30, 0)));
                else if (pick < 90) write_capacity(16'($urandom_range(200, 31)));
                else if (pick < 95) write_capacity(16'hFFFF);
                else                write_capacity(16'($urandom_range(16'hFFFF, 0)));
            end
            len = $urandom_range(14, 1);
            for (int k = 0; k < len; k++) begin
                // a few strings run on without a final marker
                fin = (k == len - 1 && $urandom_range(9) != 0) ||
                      ($urandom_range(99) < 3);
                send_item(rand_code_point(), fin);
            end
        end
    endtask

    task automatic test_full_stall();
        write_capacity(16'hFFFF);
        stall_req = 1'b1;
        for (int k = 0; k < 24; k++)
            send_item($urandom_range(32'h10FFFF, 32'h10000), k == 23);
        wait_idle();
    endtask

    task automatic test_no_idle_burst();
        write_capacity(16'hFFFF);
        idle_en = 1'b0;
        for (int k = 0; k < 40; k++)
            send_item(rand_code_point(), $urandom_range(9) == 0);
        wait_idle();
        idle_en = 1'b1;
    endtask

    // Receiver: random pops, or a long hold when a stall is requested
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_pop <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end else begin
                i_pop <= !idle_en || ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && i_pop && !o_empty) begin
            results_popped++;
            if (utf8_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
                err_count++;
            end else begin
                want = utf8_expected.pop_front();
                check_field("out_byte", want.out_byte, o_result.out_byte);
                check_field("byte_valid", want.byte_valid, o_result.byte_valid);
                check_field("last_of_run", want.last_of_run, o_result.last_of_run);
                check_field("status", want.status, o_result.status);
                check_field("bytes_total", want.bytes_total, o_result.bytes_total);
            end
        end
    end

    initial begin : main
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_encodings();
        test_capacity_edges();
        test_random_strings();
        test_full_stall();
        test_no_idle_burst();
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d code points, checked %0d results, %0d capacity writes.",
                 items_sent, results_popped, cfg_writes);
        $display("Covered all encoding lengths, NUL/no-room halts, a full stall, a burst.");
        if (err_count == 0 && utf8_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
